@@ sv/assert_macros.svh @@
// Assertion macros used by the checker module of the tap-tempo meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is switched off while reset is high.
`define AST_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked property that also holds across reset.
`define AST_ALL(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ sv/ttbpm_pkg.sv @@
// Types and constants shared by the tap-tempo meter modules.
package ttbpm_pkg;

  // Microseconds in one minute, and the bits needed to hold it.
  localparam int unsigned US_MIN_BITS = 26;
  localparam logic [US_MIN_BITS-1:0] US_PER_MIN = 26'd60000000;

  // Timeout after reset, in microseconds.
  localparam int unsigned TIMEOUT_BITS = 24;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = 24'd3000000;

  // Output field widths and their saturation values.
  localparam int unsigned Q8_BITS    = 24;
  localparam int unsigned WHOLE_BITS = 16;
  localparam int unsigned TAPS_BITS  = 16;
  localparam logic [Q8_BITS-1:0]    Q8_MAX    = '1;
  localparam logic [WHOLE_BITS-1:0] WHOLE_MAX = '1;
  localparam logic [TAPS_BITS-1:0]  TAPS_MAX  = '1;

  // Quotient of the divider: Q8 result plus one guard bit for saturation.
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned QUOT_BITS = Q8_BITS + 1;
  // Dividend bits that sit above the quotient window, as a shift of the numerator.
  localparam int unsigned SAT_SHIFT = QUOT_BITS - FRAC_BITS;

  // Input commands.
  typedef enum logic {
    CMD_TAP   = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // Sequencer of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  // Sequencer of the divider.
  typedef enum logic [1:0] {
    DV_IDLE,
    DV_LOAD,
    DV_CHECK,
    DV_STEP
  } div_state_t;

  // Status returned by the divider.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

@@ sv/ttbpm_div.sv @@
// Restoring divider with one shared subtractor: Q8 quotient and an overflow flag.
module ttbpm_div #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned NUM_W     = 42
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [NUM_W-1:0]                    num,
  input  logic [TIME_BITS-1:0]                den,
  output logic [ttbpm_pkg::QUOT_BITS-1:0]     quot,
  output ttbpm_pkg::div_stat_t                stat
);

  localparam int unsigned QB   = ttbpm_pkg::QUOT_BITS;
  localparam int unsigned SH   = ttbpm_pkg::SAT_SHIFT;
  localparam int unsigned FB   = ttbpm_pkg::FRAC_BITS;
  localparam int unsigned RW_A = TIME_BITS + 1;
  localparam int unsigned RW_B = NUM_W - SH + 1;
  localparam int unsigned RW   = (RW_A > RW_B) ? RW_A : RW_B;
  localparam int unsigned CW   = $clog2(QB + 1);

  ttbpm_pkg::div_state_t state, state_next;
  logic [RW-1:0]  rem;
  logic [QB-1:0]  shreg;
  logic [CW-1:0]  cnt;
  logic           done;
  logic           ovf;

  logic [RW-1:0]  oper;
  logic [RW:0]    diff;
  logic           borrow;

  // The one subtractor: the raw high part during the range check, the shifted
  // partial remainder during each quotient step.
  always_comb begin
    if (state == ttbpm_pkg::DV_CHECK) begin
      oper = rem;
    end else begin
      oper = {rem[RW-2:0], shreg[QB-1]};
    end
    diff   = {1'b0, oper} - (RW + 1)'(den);
    borrow = diff[RW];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ttbpm_pkg::DV_IDLE: begin
        if (start) begin
          state_next = ttbpm_pkg::DV_LOAD;
        end
      end
      ttbpm_pkg::DV_LOAD: begin
        state_next = ttbpm_pkg::DV_CHECK;
      end
      ttbpm_pkg::DV_CHECK: begin
        state_next = borrow ? ttbpm_pkg::DV_STEP : ttbpm_pkg::DV_IDLE;
      end
      ttbpm_pkg::DV_STEP: begin
        if (cnt == CW'(1)) begin
          state_next = ttbpm_pkg::DV_IDLE;
        end
      end
      default: state_next = ttbpm_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttbpm_pkg::DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == ttbpm_pkg::DV_CHECK) && !borrow) ||
               ((state == ttbpm_pkg::DV_STEP) && (cnt == CW'(1)));
    end
  end

  // Datapath: the dividend is num * 2^8; anything at or above den * 2^25
  // cannot fit the quotient window and is flagged as overflow.
  // The caller registers num and den when it raises start and holds them until done,
  // so the load cycle takes num straight from the port.
  always_ff @(posedge clk) begin
    case (state)
      ttbpm_pkg::DV_LOAD: begin
        rem   <= RW'(num[NUM_W-1:SH]);
        shreg <= {num[SH-1:0], {FB{1'b0}}};
        cnt   <= CW'(QB);
        quot  <= '0;
        ovf   <= 1'b0;
      end
      ttbpm_pkg::DV_CHECK: begin
        ovf <= !borrow;
      end
      ttbpm_pkg::DV_STEP: begin
        rem   <= borrow ? oper : diff[RW-1:0];
        quot  <= {quot[QB-2:0], !borrow};
        shreg <= {shreg[QB-2:0], 1'b0};
        cnt   <= cnt - CW'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat.done = done;
  assign stat.ovf  = ovf;

endmodule

@@ sv/tap_tempo_bpm_meter_top.sv @@
// Top level of the tap-tempo meter: run state, sequencer and output register.
//
//   channel  | handshake                  | word
//   ---------+----------------------------+------------------------------------------
//   in       | in_valid / in_stall        | command, timestamp_us
//   out      | out_valid / out_stall      | bpm_known, bpm_q8, bpm_rounded, tap_count
//   config   | cfg_wr_en (no wait)        | cfg_wr_data -> timeout_us
//
// A tap that yields a tempo goes through the check state, the divider's load, range check,
// 25 one-bit steps through its single subtractor and done. A tempo beyond the quotient range
// skips the steps; clear commands, restarting taps and zero elapsed time skip the divider.
// in_stall is high until the result enters the output register, so the next word can be
// taken in the following cycle; a result waiting under out_stall does not hold back the next
// input word. Synchronous reset clears the run and out_valid and sets the default timeout.
module tap_tempo_bpm_meter_top #(
  parameter int unsigned TIME_BITS  = 32,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 command,
  input  logic [TIME_BITS-1:0]                 timestamp_us,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 bpm_known,
  output logic [ttbpm_pkg::Q8_BITS-1:0]        bpm_q8,
  output logic [ttbpm_pkg::WHOLE_BITS-1:0]     bpm_rounded,
  output logic [ttbpm_pkg::TAPS_BITS-1:0]      tap_count,
  input  logic                                 cfg_wr_en,
  input  logic [ttbpm_pkg::TIMEOUT_BITS-1:0]   cfg_wr_data
);

  localparam int unsigned NUM_W  = COUNT_BITS + ttbpm_pkg::US_MIN_BITS;
  localparam int unsigned TAPW   = COUNT_BITS + 1;
  localparam int unsigned QB     = ttbpm_pkg::QUOT_BITS;
  localparam int unsigned HALF_W = QB - 7;

  ttbpm_pkg::state_t state, state_next;

  logic [ttbpm_pkg::TIMEOUT_BITS-1:0] timeout_us;
  logic [TIME_BITS-1:0]  first_tap_time;
  logic [TIME_BITS-1:0]  previous_tap_time;
  logic [COUNT_BITS-1:0] interval_count;

  logic                  cmd_r;
  logic [TIME_BITS-1:0]  now_r;
  logic [TIME_BITS-1:0]  elapsed;
  logic [NUM_W-1:0]      num;
  logic [TAPW-1:0]       taps;

  logic                               res_known;
  logic [ttbpm_pkg::Q8_BITS-1:0]      res_q8;
  logic [ttbpm_pkg::WHOLE_BITS-1:0]   res_whole;
  logic [ttbpm_pkg::TAPS_BITS-1:0]    res_taps;

  logic [TIME_BITS-1:0]  gap;
  logic [TIME_BITS-1:0]  elapsed_c;
  logic                  restart;
  logic                  div_start;
  logic [QB-1:0]         quot;
  ttbpm_pkg::div_stat_t  dstat;
  logic [HALF_W:0]       half_up;
  logic [HALF_W-1:0]     whole_c;
  logic                  in_acc;
  logic                  out_load;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state != ttbpm_pkg::ST_IDLE);
  assign out_load = (state == ttbpm_pkg::ST_DONE) && (!out_valid || !out_stall);

  // Time since the previous and the first tap, modulo 2^TIME_BITS.
  assign gap       = now_r - previous_tap_time;
  assign elapsed_c = now_r - first_tap_time;
  assign restart   = (interval_count == '0) || (gap >= TIME_BITS'(timeout_us));
  assign div_start = (state == ttbpm_pkg::ST_CHECK) && (cmd_r == ttbpm_pkg::CMD_TAP) &&
                     !restart && (elapsed_c != '0);

  // Rounded whole BPM: floor(2*num/elapsed) is the Q8 quotient without its low 7 bits.
  assign half_up = {1'b0, quot[QB-1:7]} + (HALF_W + 1)'(1);
  assign whole_c = half_up[HALF_W:1];

  // Saturating tap count.
  function automatic logic [ttbpm_pkg::TAPS_BITS-1:0] sat_taps(input logic [TAPW-1:0] t);
    logic [31:0] wide;
    wide = 32'(t);
    if (wide > 32'(ttbpm_pkg::TAPS_MAX)) begin
      sat_taps = ttbpm_pkg::TAPS_MAX;
    end else begin
      sat_taps = ttbpm_pkg::TAPS_BITS'(wide);
    end
  endfunction

  ttbpm_div #(
    .TIME_BITS (TIME_BITS),
    .NUM_W     (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (elapsed),
    .quot  (quot),
    .stat  (dstat)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ttbpm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = ttbpm_pkg::ST_CHECK;
        end
      end
      ttbpm_pkg::ST_CHECK: begin
        state_next = div_start ? ttbpm_pkg::ST_DIV : ttbpm_pkg::ST_DONE;
      end
      ttbpm_pkg::ST_DIV: begin
        if (dstat.done) begin
          state_next = ttbpm_pkg::ST_DONE;
        end
      end
      ttbpm_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = ttbpm_pkg::ST_IDLE;
        end
      end
      default: state_next = ttbpm_pkg::ST_IDLE;
    endcase
  end

  // Control state, run state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ttbpm_pkg::ST_IDLE;
      timeout_us        <= ttbpm_pkg::TIMEOUT_RESET;
      first_tap_time    <= '0;
      previous_tap_time <= '0;
      interval_count    <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        timeout_us <= cfg_wr_data;
      end
      if (state == ttbpm_pkg::ST_CHECK) begin
        if (cmd_r == ttbpm_pkg::CMD_CLEAR) begin
          interval_count <= '0;
        end else if (restart) begin
          first_tap_time    <= now_r;
          previous_tap_time <= now_r;
          interval_count    <= COUNT_BITS'(1);
        end else begin
          previous_tap_time <= now_r;
          if (interval_count != '1) begin
            interval_count <= interval_count + COUNT_BITS'(1);
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input capture, operands of the divider and the pending result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= command;
      now_r <= timestamp_us;
    end
    if (state == ttbpm_pkg::ST_CHECK) begin
      elapsed <= elapsed_c;
      num     <= NUM_W'(interval_count) * NUM_W'(ttbpm_pkg::US_PER_MIN);
      taps    <= TAPW'(interval_count) + TAPW'(1);
      if (cmd_r == ttbpm_pkg::CMD_CLEAR) begin
        res_taps <= '0;
      end else if (restart) begin
        res_taps <= ttbpm_pkg::TAPS_BITS'(1);
      end else begin
        res_taps <= sat_taps(TAPW'(interval_count) + TAPW'(1));
      end
      res_known <= 1'b0;
      res_q8    <= '0;
      res_whole <= '0;
    end
    if ((state == ttbpm_pkg::ST_DIV) && dstat.done) begin
      res_known <= 1'b1;
      res_taps  <= sat_taps(taps);
      if (dstat.ovf || quot[QB-1]) begin
        res_q8 <= ttbpm_pkg::Q8_MAX;
      end else begin
        res_q8 <= quot[ttbpm_pkg::Q8_BITS-1:0];
      end
      if (dstat.ovf || (32'(whole_c) > 32'(ttbpm_pkg::WHOLE_MAX))) begin
        res_whole <= ttbpm_pkg::WHOLE_MAX;
      end else begin
        res_whole <= ttbpm_pkg::WHOLE_BITS'(whole_c);
      end
    end
    if (out_load) begin
      bpm_known   <= res_known;
      bpm_q8      <= res_q8;
      bpm_rounded <= res_whole;
      tap_count   <= res_taps;
    end
  end

endmodule

@@ sv/ttbpm_chk.sv @@
// Port-level checker for the tap-tempo meter, bound to its top level.
`include "assert_macros.svh"

module ttbpm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        bpm_known,
  input logic [23:0] bpm_q8,
  input logic [15:0] bpm_rounded,
  input logic [15:0] tap_count
);

  // A word in flight holds off the next one.
  `AST_CLK(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall, "input not held off after accept")

  // An unknown tempo carries zero tempo fields.
  `AST_CLK(a_unknown_zero, clk, rst, (out_valid && !bpm_known) |-> (bpm_q8 == 24'd0 && bpm_rounded == 16'd0), "unknown tempo with nonzero fields")

  // A known tempo needs at least two taps in the run.
  `AST_CLK(a_known_taps, clk, rst, (out_valid && bpm_known) |-> (tap_count >= 16'd2), "known tempo with fewer than two taps")

  // A stalled result word stays put.
  `AST_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(bpm_q8) && $stable(tap_count)), "stalled result changed")

  // Reset empties the output register.
  `AST_ALL(a_rst_clears, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind tap_tempo_bpm_meter_top ttbpm_chk u_ttbpm_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .bpm_known   (bpm_known),
  .bpm_q8      (bpm_q8),
  .bpm_rounded (bpm_rounded),
  .tap_count   (tap_count)
);
